### rtl/bchd_pkg.sv
// Shared constants, types and codes for the breath cycle hysteresis detector.
package bchd_pkg;

   localparam int LEVEL_MIN  = 0;
   localparam int LEVEL_MAX  = 7;
   localparam int RING_DEPTH = 16;

   localparam int LEVEL_W = 8;
   localparam int LEN_W   = 16;
   localparam int IDX_W   = 4;
   localparam int SLOT_W  = $clog2(RING_DEPTH);

   // level bounds and span, all taken in 8 bits
   localparam logic [LEVEL_W-1:0] LVL_LO      = LEVEL_W'(LEVEL_MIN);
   localparam logic [LEVEL_W-1:0] LVL_HI      = LEVEL_W'(LEVEL_MAX);
   localparam logic [LEVEL_W-1:0] SPAN        = LEVEL_W'(LEVEL_MAX - LEVEL_MIN);
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = SPAN >> 1;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef enum logic [1:0] {
      OP_STRETCH      = 2'd0,
      OP_SHRINK       = 2'd1,
      OP_READ_STRETCH = 2'd2,
      OP_READ_SHRINK  = 2'd3
   } op_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               breath_start;
      logic               shrink_saved;
      logic               stretch_saved;
      logic [LEN_W-1:0]   saved_length;
      logic [IDX_W-1:0]   saved_slot;
   } result_type;

   typedef struct packed {
      logic             stretch_we;
      logic             shrink_we;
      slot_type         addr;
      logic [LEN_W-1:0] data;
   } ring_wr_type;

endpackage

### rtl/breath_cycle_hysteresis_detector.sv
// Top level of the breath cycle hysteresis detector.
//
// Request channel (req_): one transaction per belt event or ring read.
//   req_tuser carries the operation: stretch, shrink, read stretch ring,
//   read shrink ring. req_tdata carries the ring slot to read.
// Response channel (rsp_): exactly one transaction per request, in order,
//   with the level after the event, breath start flag, the length stored in a
//   ring on this event (with its slot) and the ring entry for a read.
// Path: an accepted request moves through the stage one register, then the
//   output register, to rsp_tvalid. Throughput: one transaction per cycle
//   while rsp_tready holds. Each ring RAM has one write and one read port;
//   back-to-back events and reads need no interlock: each write precedes the next read.
// Pipeline: the tracker updates its state at acceptance and issues the ring
//   write and read; stage one waits for the registered RAM data; the output
//   register holds the response. A stalled rsp_tready fills the output
//   register, then stage one, then drops req_tready; nothing is lost.
// Reset (synchronous, active high): level and last extreme go to half the
//   span, run counters and slot pointers to zero, ring valid bits clear so
//   every ring entry reads as zero until written. Pipeline empties.
module breath_cycle_hysteresis_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] read_index, [7:4] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [7:0] level, [8] breath_start, [9] shrink_saved,
                                    // [10] stretch_saved, [26:11] saved_length,
                                    // [30:27] saved_slot, [46:31] read_data, [47] zero
);

   logic                                    accept;
   logic                                    s1_advance;
   bchd_pkg::op_type                        op;
   logic [bchd_pkg::IDX_W-1:0]              rd_index;
   logic [bchd_pkg::SLOT_W+bchd_pkg::IDX_W-1:0] rd_index_wide;
   bchd_pkg::slot_type                      rd_addr;
   logic                                    rd_in_range;
   bchd_pkg::result_type                    res;
   bchd_pkg::ring_wr_type                   wr;
   logic [bchd_pkg::LEN_W-1:0]              stretch_rd;
   logic [bchd_pkg::LEN_W-1:0]              shrink_rd;
   logic [bchd_pkg::LEN_W-1:0]              read_data;

   logic                 s1_valid_ff, s1_valid_in;
   bchd_pkg::result_type s1_res_ff;
   logic                 s1_take_stretch_ff;
   logic                 s1_take_shrink_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [47:0]          rsp_data_ff;

   assign op       = bchd_pkg::op_type'(req_tuser);
   assign rd_index = req_tdata[bchd_pkg::IDX_W-1:0];
   assign rd_index_wide = {{bchd_pkg::SLOT_W{1'b0}}, rd_index};
   assign rd_addr       = rd_index_wide[bchd_pkg::SLOT_W-1:0];
   assign rd_in_range   = (32'(rd_index) < bchd_pkg::RING_DEPTH);

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept     = req_tvalid && req_tready;

   bchd_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .op     (op),
      .res    (res),
      .wr     (wr)
   );

   bchd_ring u_stretch_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr.stretch_we),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (stretch_rd)
   );

   bchd_ring u_shrink_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr.shrink_we),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (shrink_rd)
   );

   // stage one: RAM data arrives, pick the ring asked for
   always_comb begin
      read_data = '0;
      if (s1_take_stretch_ff) begin
         read_data = stretch_rd;
      end else if (s1_take_shrink_ff) begin
         read_data = shrink_rd;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff          <= res;
         s1_take_stretch_ff <= (op == bchd_pkg::OP_READ_STRETCH) && rd_in_range;
         s1_take_shrink_ff  <= (op == bchd_pkg::OP_READ_SHRINK) && rd_in_range;
      end
      if (s1_advance) begin
         rsp_data_ff <= {1'b0, read_data, s1_res_ff.saved_slot, s1_res_ff.saved_length,
                         s1_res_ff.stretch_saved, s1_res_ff.shrink_saved,
                         s1_res_ff.breath_start, s1_res_ff.level};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // at most one ring is written per transaction
   assert property (@(posedge clock) disable iff (reset)
      !(wr.stretch_we && wr.shrink_we))
      else $error("both rings written by one transaction");

   // a breath start only happens with the level pinned at the top
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[8] |-> rsp_data_ff[7:0] == bchd_pkg::LVL_HI)
      else $error("breath start away from upper level");

   // read data and stored lengths never share a response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[46:31] != '0) |-> !rsp_data_ff[9] && !rsp_data_ff[10])
      else $error("read data on an event response");

   // ring writes only happen on accepted transactions
   assert property (@(posedge clock) disable iff (reset)
      (wr.stretch_we || wr.shrink_we) |-> accept)
      else $error("ring write without an accepted request");

endmodule

### rtl/bchd_ring.sv
// Length ring: synchronous RAM with per-entry valid bits cleared at reset.
module bchd_ring (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  bchd_pkg::slot_type        wr_addr,
   input  logic [bchd_pkg::LEN_W-1:0] wr_data,
   input  logic                      rd_en,
   input  bchd_pkg::slot_type        rd_addr,
   output logic [bchd_pkg::LEN_W-1:0] rd_data
);

   logic [bchd_pkg::LEN_W-1:0]   ring_mem_ff [bchd_pkg::RING_DEPTH];
   logic [bchd_pkg::RING_DEPTH-1:0] valid_ff;
   logic [bchd_pkg::LEN_W-1:0]   rd_data_ff;
   logic                         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### rtl/bchd_tracker.sv
// Hysteresis level counter, extreme tracking, run counters and ring slot pointers.
module bchd_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  bchd_pkg::op_type       op,
   output bchd_pkg::result_type   res,
   output bchd_pkg::ring_wr_type  wr
);

   logic [bchd_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [bchd_pkg::LEVEL_W-1:0] last_ff, last_in;
   logic                         enabled_ff, enabled_in;
   logic [bchd_pkg::LEN_W-1:0]   shrink_run_ff, shrink_run_in;
   logic [bchd_pkg::LEN_W-1:0]   stretch_run_ff, stretch_run_in;
   bchd_pkg::slot_type           stretch_slot_ff, stretch_slot_in;
   bchd_pkg::slot_type           shrink_slot_ff, shrink_slot_in;
   logic                         pinned;
   logic [bchd_pkg::LEN_W-1:0]   shrink_len;
   logic [bchd_pkg::LEN_W-1:0]   stretch_len;

   function automatic logic [bchd_pkg::LEN_W-1:0] sat_add(
      input logic [bchd_pkg::LEN_W-1:0]   a,
      input logic [bchd_pkg::LEVEL_W-1:0] b
   );
      logic [bchd_pkg::LEN_W:0] sum;
      sum = {1'b0, a} + (bchd_pkg::LEN_W + 1)'(b);
      return sum[bchd_pkg::LEN_W] ? '1 : sum[bchd_pkg::LEN_W-1:0];
   endfunction

   function automatic bchd_pkg::slot_type slot_next(input bchd_pkg::slot_type s);
      return (s == bchd_pkg::SLOT_W'(bchd_pkg::RING_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [bchd_pkg::IDX_W-1:0] slot_low(input bchd_pkg::slot_type s);
      logic [bchd_pkg::SLOT_W+bchd_pkg::IDX_W-1:0] wide;
      wide = {{bchd_pkg::IDX_W{1'b0}}, s};
      return wide[bchd_pkg::IDX_W-1:0];
   endfunction

   assign shrink_len  = sat_add(shrink_run_ff, bchd_pkg::SPAN);
   assign stretch_len = sat_add(stretch_run_ff, bchd_pkg::SPAN);

   always_comb begin
      level_in        = level_ff;
      last_in         = last_ff;
      enabled_in      = enabled_ff;
      shrink_run_in   = shrink_run_ff;
      stretch_run_in  = stretch_run_ff;
      stretch_slot_in = stretch_slot_ff;
      shrink_slot_in  = shrink_slot_ff;
      pinned          = 1'b0;
      res             = '0;
      wr              = '0;

      case (op)
         bchd_pkg::OP_STRETCH: begin
            if (level_ff >= bchd_pkg::LVL_HI) begin
               level_in = bchd_pkg::LVL_HI;
               pinned   = 1'b1;
            end else begin
               level_in = level_ff + 1'b1;
            end
         end
         bchd_pkg::OP_SHRINK: begin
            if (level_ff <= bchd_pkg::LVL_LO) begin
               level_in = bchd_pkg::LVL_LO;
               pinned   = 1'b1;
            end else begin
               level_in = level_ff - 1'b1;
            end
         end
         default: ;
      endcase

      if (pinned) begin
         if (level_in == bchd_pkg::LVL_HI && last_ff == bchd_pkg::LVL_LO) begin
            // exhalation over
            if (enabled_ff) begin
               wr.shrink_we       = 1'b1;
               wr.addr            = shrink_slot_ff;
               wr.data            = shrink_len;
               res.shrink_saved   = 1'b1;
               res.saved_length   = shrink_len;
               res.saved_slot     = slot_low(shrink_slot_ff);
               shrink_slot_in     = slot_next(shrink_slot_ff);
            end
            res.breath_start = 1'b1;
            enabled_in       = 1'b1;
            shrink_run_in    = '0;
         end else if (level_in == bchd_pkg::LVL_LO && last_ff == bchd_pkg::LVL_HI) begin
            // inhalation over
            if (enabled_ff) begin
               wr.stretch_we      = 1'b1;
               wr.addr            = stretch_slot_ff;
               wr.data            = stretch_len;
               res.stretch_saved  = 1'b1;
               res.saved_length   = stretch_len;
               res.saved_slot     = slot_low(stretch_slot_ff);
               stretch_slot_in    = slot_next(stretch_slot_ff);
            end
            stretch_run_in = '0;
         end else if (level_in == bchd_pkg::LVL_LO && last_ff == bchd_pkg::LVL_LO) begin
            shrink_run_in = sat_add(shrink_run_ff, bchd_pkg::LEVEL_W'(1));
         end else if (level_in == bchd_pkg::LVL_HI && last_ff == bchd_pkg::LVL_HI) begin
            stretch_run_in = sat_add(stretch_run_ff, bchd_pkg::LEVEL_W'(1));
         end
         last_in = level_in;
      end

      res.level = level_in;
      if (!accept) begin
         wr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= bchd_pkg::LEVEL_RESET;
         last_ff         <= bchd_pkg::LEVEL_RESET;
         enabled_ff      <= 1'b0;
         shrink_run_ff   <= '0;
         stretch_run_ff  <= '0;
         stretch_slot_ff <= '0;
         shrink_slot_ff  <= '0;
      end else if (accept) begin
         level_ff        <= level_in;
         last_ff         <= last_in;
         enabled_ff      <= enabled_in;
         shrink_run_ff   <= shrink_run_in;
         stretch_run_ff  <= stretch_run_in;
         stretch_slot_ff <= stretch_slot_in;
         shrink_slot_ff  <= shrink_slot_in;
      end
   end

endmodule
